/* src/lir_pkg.sv */
// Shared types and constants for the linear interpolation resampler.
// Used by lir_interp_unit and linear_interp_resampler_top.
`timescale 1ns / 1ps
`default_nettype none
package lir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int PHASE_W  = 32;
  localparam int RATIO_W  = 21;
  localparam int LEN_W    = 15;
  localparam int ADDR_W   = 4;
  localparam int CNT_W    = 2;

  localparam logic [1:0] REG_RATE    = 2'd0;
  localparam logic [1:0] REG_IN_LEN  = 2'd1;
  localparam logic [1:0] REG_OUT_LEN = 2'd2;

  localparam logic [RATIO_W-1:0] RATIO_MIN   = RATIO_W'(1 << (FRAC_W - 1));
  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(1 << FRAC_W);
  localparam logic [LEN_W-1:0]   LEN_MIN     = LEN_W'(2);
  localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(2048);
  localparam logic [CNT_W-1:0]   MAX_RUN     = CNT_W'(2);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t           prev;
    sample_t           cur;
    logic [FRAC_W-1:0] frac;
  } interp_op_t;

endpackage
`default_nettype wire

/* src/lir_interp_unit.sv */
// Shared interpolation datapath: prev + (cur - prev) * frac, rounded half up.
// Depends on lir_pkg for sample width, fraction width and the operand struct.
`timescale 1ns / 1ps
`default_nettype none
module lir_interp_unit (
  input  wire lir_pkg::interp_op_t op,
  output lir_pkg::sample_t         result
);

  localparam int SW  = lir_pkg::SAMPLE_W;
  localparam int FW  = lir_pkg::FRAC_W;
  localparam int PW  = SW + 1 + FW + 1;
  localparam int NW  = PW + 1;

  logic signed [SW:0]   diff;
  logic signed [FW:0]   frac_s;
  logic signed [PW-1:0] prod;
  logic signed [NW-1:0] num;

  assign diff   = SW'(op.cur) - SW'(op.prev) + (SW + 1)'(0);
  assign frac_s = $signed({1'b0, op.frac});
  assign prod   = PW'(diff) * PW'(frac_s);
  assign num    = (NW'(op.prev) <<< FW) + NW'(prod) + NW'(1 << (FW - 1));
  assign result = num[FW+SW-1:FW];

endmodule
`default_nettype wire

/* src/linear_interp_resampler_top.sv */
// Linear interpolation resampler for complex I/Q streams, top level.
// Depends on lir_pkg and lir_interp_unit.
//
// Usage:
//   Input words arrive on s_t* (s_tdata = sample_i, sample_q). Each word may
//   cause zero, one or two output words on m_t* (m_tdata = out_i, out_q;
//   m_tuser = block_end; m_tlast = last_of_run, set on the last word caused
//   by an input). Registers rate_ratio (0x0), in_block_len (0x4) and
//   out_block_len (0x8) are written over the APB port; the user must write
//   them only while idle, since the block itself does not enforce it. An input
//   word passes through the accept state, the check state, then per output two
//   passes through the single shared multiplier (I, then Q) plus a load into
//   the output register, and a final update state. s_tready is high only
//   between words. An output word waits in the output register; the next input
//   is taken while it waits, but a new output is loaded only once the previous
//   one has been taken, so a stalled receiver holds the sequencer. Reset clears
//   the sample history, the block position, the phase and the output valid and
//   restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module linear_interp_resampler_top (
  input  wire                       clk,
  input  wire                       rst,
  // s_tdata: [15:0] sample_i, [31:16] sample_q
  input  wire                       s_tvalid,
  output logic                      s_tready,
  input  wire  [31:0]               s_tdata,
  // m_tdata: [15:0] out_i, [31:16] out_q; m_tuser: [0] block_end
  output logic                      m_tvalid,
  input  wire                       m_tready,
  output logic [31:0]               m_tdata,
  output logic                      m_tuser,
  output logic                      m_tlast,
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire  [lir_pkg::ADDR_W-1:0] paddr,
  input  wire  [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int SW = lir_pkg::SAMPLE_W;
  localparam int FW = lir_pkg::FRAC_W;
  localparam int PH = lir_pkg::PHASE_W;
  localparam int RW = lir_pkg::RATIO_W;
  localparam int LW = lir_pkg::LEN_W;
  localparam int CW = lir_pkg::CNT_W;
  localparam int BW = PH - FW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL_I = 3'd2;
  localparam logic [2:0] S_MUL_Q = 3'd3;
  localparam logic [2:0] S_LAST  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]            state;
  logic [RW-1:0]         rate_ratio;
  logic [LW-1:0]         in_block_len;
  logic [LW-1:0]         out_block_len;
  lir_pkg::sample_t      cur_i, cur_q, prev_i, prev_q, res_i, res_q;
  logic                  res_be;
  logic [LW-1:0]         in_index;
  logic [LW-1:0]         out_index;
  logic [PH-1:0]         phase;
  logic [CW-1:0]         run_cnt;

  logic [RW-1:0]         ratio;
  logic [LW-1:0]         in_len, out_len;
  logic [BW-1:0]         base_want;
  logic                  more;
  logic [PH:0]           phase_sum;
  logic [PH-1:0]         phase_next;
  logic                  out_free;
  logic                  cfg_wr;
  lir_pkg::interp_op_t   op;
  lir_pkg::sample_t      interp_res;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign ratio   = (rate_ratio < lir_pkg::RATIO_MIN) ? lir_pkg::RATIO_MIN : rate_ratio;
  assign in_len  = (in_block_len < lir_pkg::LEN_MIN) ? lir_pkg::LEN_MIN : in_block_len;
  assign out_len = (out_block_len < lir_pkg::LEN_MIN) ? lir_pkg::LEN_MIN : out_block_len;

  assign base_want = BW'(in_index) - BW'(1);
  assign more = (in_index != '0) && (run_cnt != lir_pkg::MAX_RUN) &&
                (out_index < out_len - LW'(1)) && (phase[PH-1:FW] == base_want);

  assign phase_sum  = (PH + 1)'(phase) + (PH + 1)'(ratio);
  assign phase_next = phase_sum[PH] ? '1 : phase_sum[PH-1:0];

  always_comb begin
    op.frac = phase[FW-1:0];
    if (state == S_MUL_Q) begin
      op.prev = prev_q;
      op.cur  = cur_q;
    end else begin
      op.prev = prev_i;
      op.cur  = cur_i;
    end
  end

  lir_interp_unit u_interp (
    .op     (op),
    .result (interp_res)
  );

  always_comb begin
    unique case (paddr[3:2])
      lir_pkg::REG_RATE:    prdata = 32'(rate_ratio);
      lir_pkg::REG_IN_LEN:  prdata = 32'(in_block_len);
      lir_pkg::REG_OUT_LEN: prdata = 32'(out_block_len);
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_ratio    <= lir_pkg::RATIO_RESET;
      in_block_len  <= lir_pkg::LEN_RESET;
      out_block_len <= lir_pkg::LEN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        lir_pkg::REG_RATE:    rate_ratio    <= pwdata[RW-1:0];
        lir_pkg::REG_IN_LEN:  in_block_len  <= pwdata[LW-1:0];
        lir_pkg::REG_OUT_LEN: out_block_len <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      prev_i    <= '0;
      prev_q    <= '0;
      in_index  <= '0;
      out_index <= '0;
      phase     <= '0;
      run_cnt   <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (state == S_LAST && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cur_i   <= s_tdata[SW-1:0];
            cur_q   <= s_tdata[2*SW-1:SW];
            run_cnt <= '0;
            state   <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= more ? S_MUL_I : S_DONE;
        end
        S_MUL_I: begin
          res_i <= interp_res;
          state <= S_MUL_Q;
        end
        S_MUL_Q: begin
          res_q     <= interp_res;
          res_be    <= (out_index == out_len - LW'(2));
          out_index <= out_index + LW'(1);
          phase     <= phase_next;
          run_cnt   <= run_cnt + CW'(1);
          state     <= S_LAST;
        end
        S_LAST: begin
          if (out_free) begin
            m_tdata  <= {res_q, res_i};
            m_tuser  <= res_be;
            m_tlast  <= !more;
            state    <= more ? S_MUL_I : S_DONE;
          end
        end
        S_DONE: begin
          prev_i <= cur_i;
          prev_q <= cur_q;
          if (in_index != '0 && in_index >= in_len - LW'(1)) begin
            in_index  <= LW'(1);
            out_index <= '0;
            phase     <= '0;
          end else begin
            in_index <= in_index + LW'(1);
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/lir_checker.sv */
// Port-level checks for linear_interp_resampler_top, attached by bind.
// Depends only on the port names of the top level.
`timescale 1ns / 1ps
`default_nettype none
module lir_port_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        s_tvalid,
  input wire                        s_tready,
  input wire                        m_tvalid,
  input wire                        m_tready,
  input wire [31:0]                 m_tdata,
  input wire                        m_tuser,
  input wire                        m_tlast,
  input wire                        pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again right after a word");

  a_block_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("block end word not marked last of run");

  a_reset_state: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid && pready)
    else $error("bad state after reset");

endmodule

bind linear_interp_resampler_top lir_port_checker u_lir_port_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast),
  .pready   (pready)
);
`default_nettype wire
